### sv/kdst_pkg.sv
// Shared types and constants of the keyed duration statistics table.
package kdst_pkg;

  localparam int KeyW     = 64;
  localparam int DurW     = 32;
  localparam int IdxOutW  = 4;
  localparam int StatW    = 3;
  localparam int UsedOutW = 5;

  typedef enum logic [0:0] {
    OP_RECORD = 1'b0,
    OP_READ   = 1'b1
  } op_e;

  typedef enum logic [StatW-1:0] {
    ST_UPDATED = 3'd0,
    ST_NEW     = 3'd1,
    ST_FULL    = 3'd2,
    ST_READ    = 3'd3,
    ST_UNUSED  = 3'd4
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SEARCH,
    S_MUL,
    S_ADD,
    S_DIV,
    S_WRITE,
    S_READ,
    S_OUT
  } state_e;

  typedef struct packed {
    logic [KeyW-1:0] key;
    logic [DurW-1:0] last;
    logic [DurW-1:0] min;
    logic [DurW-1:0] max;
    logic [DurW-1:0] mean;
    logic [DurW-1:0] count;
  } entry_t;

endpackage

### sv/kdst_if.sv
// Request and response channel interfaces of the statistics table.
interface kdst_req_if import kdst_pkg::*; ();
  logic                valid;
  logic                ready;
  logic                op;
  logic [KeyW-1:0]     key;
  logic [DurW-1:0]     duration_us;
  logic [IdxOutW-1:0]  index;

  modport source (output valid, op, key, duration_us, index, input ready);
  modport sink (input valid, op, key, duration_us, index, output ready);
endinterface

interface kdst_rsp_if import kdst_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [StatW-1:0]    status;
  logic [IdxOutW-1:0]  entry_index;
  logic [KeyW-1:0]     entry_key;
  logic [DurW-1:0]     last_us;
  logic [DurW-1:0]     min_us;
  logic [DurW-1:0]     max_us;
  logic [DurW-1:0]     mean_us;
  logic [DurW-1:0]     sample_count;
  logic [UsedOutW-1:0] entries_used;

  modport source (output valid, status, entry_index, entry_key, last_us, min_us, max_us,
                  mean_us, sample_count, entries_used, input ready);
  modport sink (input valid, status, entry_index, entry_key, last_us, min_us, max_us,
                mean_us, sample_count, entries_used, output ready);
endinterface

### sv/kdst_div.sv
// Radix-2 restoring divider for a 64-bit dividend whose quotient fits in 32 bits.
module kdst_div import kdst_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  input  logic [63:0]     dividend_i,
  input  logic [DurW:0]   divisor_i,
  output logic            done_o,
  output logic [DurW-1:0] quotient_o
);

  logic            busy_q, busy_d;
  logic            done_q, done_d;
  logic [4:0]      cnt_q, cnt_d;
  logic [DurW:0]   rem_q, rem_d;
  logic [DurW-1:0] low_q, low_d;
  logic [DurW:0]   div_q, div_d;
  logic [DurW+1:0] trial;
  logic [DurW+2:0] diff;
  logic            ge;

  always_comb begin
    trial  = {rem_q, low_q[DurW-1]};
    diff   = {1'b0, trial} - {2'b00, div_q};
    ge     = ~diff[DurW+2];
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    low_d  = low_q;
    div_d  = div_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      rem_d  = {1'b0, dividend_i[63:32]};
      low_d  = dividend_i[31:0];
      div_d  = divisor_i;
    end else if (busy_q) begin
      rem_d = ge ? diff[DurW:0] : trial[DurW:0];
      low_d = {low_q[DurW-2:0], ge};
      cnt_d = cnt_q + 5'd1;
      if (cnt_q == 5'd31) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    low_q <= low_d;
    div_q <= div_d;
  end

  assign done_o     = done_q;
  assign quotient_o = low_q;

endmodule

### sv/keyed_duration_stats_table.sv
// Top level of the keyed duration statistics table.
// The table holds up to ENTRIES records in one memory with a registered read port, and
// takes one request at a time. A read registers the memory word and then the response.
// A record scans the used entries at one memory read per cycle; on a miss it writes a new
// entry or, if the table is full, reports a drop. A hit forms the 32x32 product, starts
// the radix-2 divider, waits for the division and writes the entry. The response is held
// until it is taken. No clearing pass runs after reset: entries at or beyond the fill
// count are never read.
module keyed_duration_stats_table import kdst_pkg::*; #(
  parameter int ENTRIES = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  kdst_req_if.sink    req_i,
  kdst_rsp_if.source  rsp_o
);

  localparam int IdxW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CntW = $clog2(ENTRIES + 1);

  typedef struct packed {
    logic req_ready;
    logic rsp_valid;
    logic mem_re;
    logic mem_we;
    logic div_start;
  } ctl_t;

  state_e          state_q, state_d;
  ctl_t            ctl;
  logic [CntW-1:0] used_q, ptr_q;
  logic            pend_q, hit_q;
  logic [IdxW-1:0] cmp_idx_q, slot_q;
  logic [KeyW-1:0] key_q;
  logic [DurW-1:0] dur_q;
  logic [63:0]     prod_q;
  entry_t          mem_q [ENTRIES];
  entry_t          rdata_q;
  entry_t          wdata;
  logic [IdxW-1:0] raddr, waddr;
  status_e         out_st_q;
  logic [IdxOutW-1:0]  out_idx_q;
  logic [UsedOutW-1:0] out_used_q;
  entry_t          out_rec_q;

  logic            accept, idx_ok, room, hit, miss;
  logic            div_done;
  logic [DurW-1:0] quotient;
  logic [DurW-1:0] new_min, new_max, new_cnt;

  assign accept = req_i.valid && ctl.req_ready;
  assign idx_ok = (32'(req_i.index) < 32'(used_q)) && (32'(req_i.index) < ENTRIES);
  assign room   = 32'(used_q) < ENTRIES;
  assign hit    = pend_q && (rdata_q.key == key_q);
  assign miss   = !hit && (ptr_q == used_q);

  assign raddr = (state_q == S_IDLE) ? IdxW'(req_i.index) : IdxW'(ptr_q);
  assign waddr = hit_q ? slot_q : IdxW'(used_q);

  always_comb begin
    new_min = ((rdata_q.count == '0) || (dur_q < rdata_q.min)) ? dur_q : rdata_q.min;
    new_max = (dur_q > rdata_q.max) ? dur_q : rdata_q.max;
    new_cnt = (rdata_q.count == '1) ? rdata_q.count : rdata_q.count + 32'd1;
    if (hit_q) begin
      wdata = '{key: rdata_q.key, last: dur_q, min: new_min, max: new_max,
                mean: quotient, count: new_cnt};
    end else begin
      wdata = '{key: key_q, last: dur_q, min: dur_q, max: dur_q, mean: dur_q,
                count: 32'd1};
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (req_i.valid) begin
          if (req_i.op == OP_READ) begin
            state_d = idx_ok ? S_READ : S_OUT;
          end else begin
            state_d = S_SEARCH;
          end
        end
      end
      S_SEARCH: begin
        if (hit) begin
          state_d = S_MUL;
        end else if (miss) begin
          state_d = room ? S_WRITE : S_OUT;
        end
      end
      S_MUL:   state_d = S_ADD;
      S_ADD:   state_d = S_DIV;
      S_DIV: begin
        if (div_done) begin
          state_d = S_WRITE;
        end
      end
      S_WRITE: state_d = S_OUT;
      S_READ:  state_d = S_OUT;
      S_OUT: begin
        if (rsp_o.ready) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    ctl = '0;
    case (state_q)
      S_IDLE: begin
        ctl.req_ready = 1'b1;
        ctl.mem_re    = req_i.valid && (req_i.op == OP_READ) && idx_ok;
      end
      S_SEARCH: ctl.mem_re    = !hit && !miss;
      S_ADD:    ctl.div_start = 1'b1;
      S_WRITE:  ctl.mem_we    = 1'b1;
      S_OUT:    ctl.rsp_valid = 1'b1;
      default:  ctl = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      used_q  <= '0;
      ptr_q   <= '0;
      pend_q  <= 1'b0;
      hit_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      if (accept) begin
        ptr_q  <= '0;
        pend_q <= 1'b0;
        hit_q  <= 1'b0;
      end
      if (state_q == S_SEARCH) begin
        if (hit) begin
          hit_q <= 1'b1;
        end else if (!miss) begin
          ptr_q  <= ptr_q + CntW'(1);
          pend_q <= 1'b1;
        end
      end
      if ((state_q == S_WRITE) && !hit_q) begin
        used_q <= used_q + CntW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      key_q  <= req_i.key;
      dur_q  <= req_i.duration_us;
      slot_q <= IdxW'(req_i.index);
      if ((req_i.op == OP_READ) && !idx_ok) begin
        out_st_q   <= ST_UNUSED;
        out_idx_q  <= '0;
        out_rec_q  <= '0;
        out_used_q <= UsedOutW'(used_q);
      end
    end
    case (state_q)
      S_SEARCH: begin
        if (hit) begin
          slot_q <= cmp_idx_q;
        end else if (miss) begin
          if (!room) begin
            out_st_q   <= ST_FULL;
            out_idx_q  <= '0;
            out_rec_q  <= '0;
            out_used_q <= UsedOutW'(used_q);
          end
        end else begin
          cmp_idx_q <= IdxW'(ptr_q);
        end
      end
      S_MUL: prod_q <= 64'(rdata_q.mean) * 64'(rdata_q.count);
      S_WRITE: begin
        out_st_q   <= hit_q ? ST_UPDATED : ST_NEW;
        out_idx_q  <= IdxOutW'(waddr);
        out_rec_q  <= wdata;
        out_used_q <= hit_q ? UsedOutW'(used_q) : UsedOutW'(used_q + CntW'(1));
      end
      S_READ: begin
        out_st_q   <= ST_READ;
        out_idx_q  <= IdxOutW'(slot_q);
        out_rec_q  <= rdata_q;
        out_used_q <= UsedOutW'(used_q);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (ctl.mem_we) begin
      mem_q[waddr] <= wdata;
    end
    if (ctl.mem_re) begin
      rdata_q <= mem_q[raddr];
    end
  end

  kdst_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (ctl.div_start),
    .dividend_i (prod_q + {32'd0, dur_q}),
    .divisor_i  ({1'b0, rdata_q.count} + 33'd1),
    .done_o     (div_done),
    .quotient_o (quotient)
  );

  assign req_i.ready        = ctl.req_ready;
  assign rsp_o.valid        = ctl.rsp_valid;
  assign rsp_o.status       = out_st_q;
  assign rsp_o.entry_index  = out_idx_q;
  assign rsp_o.entry_key    = out_rec_q.key;
  assign rsp_o.last_us      = out_rec_q.last;
  assign rsp_o.min_us       = out_rec_q.min;
  assign rsp_o.max_us       = out_rec_q.max;
  assign rsp_o.mean_us      = out_rec_q.mean;
  assign rsp_o.sample_count = out_rec_q.count;
  assign rsp_o.entries_used = out_used_q;

  a_used_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(used_q) <= ENTRIES) else $error("fill count beyond table size");

  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> !ctl.req_ready) else $error("request taken while busy");

  a_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl.rsp_valid && (out_st_q == ST_FULL) |-> 32'(used_q) == ENTRIES)
    else $error("drop reported with room left");

  a_unused_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl.rsp_valid && (out_st_q == ST_UNUSED) |-> (out_rec_q == '0) && (out_idx_q == '0))
    else $error("unused index response carries data");

  a_div_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> state_q == S_DIV) else $error("divider finished outside division");

endmodule
